/* src/pfb_pkg.sv */
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared constants, request codes, control/status structs and helpers of the
// page framebuffer draw engine.
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_PAGES   = 8;
    localparam int ROWS_PER_PAGE  = 8;
    localparam int STORE_BYTES    = SCREEN_COLUMNS * SCREEN_PAGES;

    localparam int COL_IDX_W  = $clog2(SCREEN_COLUMNS);
    localparam int PAGE_IDX_W = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
    localparam int ADDR_W     = $clog2(STORE_BYTES);

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_INVERT = 3'd1,
        REQ_HLINE  = 3'd2,
        REQ_VLINE  = 3'd3,
        REQ_WRITE  = 3'd4,
        REQ_READ   = 3'd5
    } req_t;

    typedef struct packed {
        logic load;     // capture a new request
        logic mem_rd;   // read the byte at the current position
        logic mem_wr;   // write the new byte at the current position
        logic step;     // advance column / page counters
        logic clr_wr;   // write zero during the power-up sweep
        logic out_load; // capture the result into the output register
    } pfb_cmd_t;

    typedef struct packed {
        logic skip;      // rejected or empty range
        logic need_read; // read-modify-write or read request
        logic is_read;
        logic last;      // current byte is the last of the block
        logic clr_last;  // sweep at the last address
    } pfb_status_t;

    function automatic logic [7:0] row_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] m;
        if (lo > hi)
        begin
            m = 8'h00;
        end
        else
        begin
            m = (FULL_BYTE >> (3'd7 - hi)) & (FULL_BYTE << lo);
        end
        return m;
    endfunction

endpackage

/* src/pfb_ctrl.sv */
// ----------------------------------------------------------------------------
// pfb_ctrl
// Controller: power-up sweep, request sequencing and the output handshake.
// ----------------------------------------------------------------------------
module pfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  pfb_pkg::pfb_status_t status,
    output pfb_pkg::pfb_cmd_t    cmd
);
    import pfb_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_WRITE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (status.skip)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.need_read)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = status.is_read ? ST_FINISH : ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                cmd.step   = 1'b1;
                priority if (status.last)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.need_read)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/pfb_datapath.sv */
// ----------------------------------------------------------------------------
// pfb_datapath
// Request decode, range clipping, column/page counters, frame store and the
// result register.
// ----------------------------------------------------------------------------
module pfb_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pfb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic [pfb_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    input  pfb_pkg::pfb_cmd_t                 cmd,
    output pfb_pkg::pfb_status_t              status,
    output logic [pfb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic [pfb_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    import pfb_pkg::*;

    localparam logic [8:0] COLS9     = 9'(SCREEN_COLUMNS);
    localparam logic [8:0] LAST_COL9 = 9'(SCREEN_COLUMNS - 1);
    localparam logic [4:0] PAGES5    = 5'(SCREEN_PAGES);
    localparam logic [4:0] LAST_PG5  = 5'(SCREEN_PAGES - 1);

    // input fields
    req_t       in_req;
    logic [7:0] in_col, in_tcol, in_wid, in_data;
    logic [3:0] in_pg, in_tpg, in_hgt, in_frow, in_trow;

    assign in_req  = req_t'(s_axis_tuser[2:0]);
    assign in_col  = s_axis_tdata[7:0];
    assign in_tcol = s_axis_tdata[15:8];
    assign in_pg   = s_axis_tdata[19:16];
    assign in_tpg  = s_axis_tdata[23:20];
    assign in_wid  = s_axis_tdata[31:24];
    assign in_hgt  = s_axis_tdata[35:32];
    assign in_frow = s_axis_tdata[39:36];
    assign in_trow = s_axis_tdata[43:40];
    assign in_data = s_axis_tdata[51:44];

    // decode
    logic [8:0] col9, tcol9, ccol9, ctcol9, wroom, wclip, cs9, ce9;
    logic [4:0] pg5, tpg5, cpg5, ctpg5, hroom, hclip, ps5, pe5;
    logic [2:0] frow3, trow3;
    logic       d_rej, d_empty;

    assign col9   = {1'b0, in_col};
    assign tcol9  = {1'b0, in_tcol};
    assign pg5    = {1'b0, in_pg};
    assign tpg5   = {1'b0, in_tpg};
    assign ccol9  = (col9 > LAST_COL9) ? LAST_COL9 : col9;
    assign ctcol9 = (tcol9 > LAST_COL9) ? LAST_COL9 : tcol9;
    assign cpg5   = (pg5 > LAST_PG5) ? LAST_PG5 : pg5;
    assign ctpg5  = (tpg5 > LAST_PG5) ? LAST_PG5 : tpg5;
    assign wroom  = COLS9 - col9;
    assign wclip  = ({1'b0, in_wid} > wroom) ? wroom : {1'b0, in_wid};
    assign hroom  = PAGES5 - pg5;
    assign hclip  = ({1'b0, in_hgt} > hroom) ? hroom : {1'b0, in_hgt};
    assign frow3  = (in_frow > 4'd7) ? 3'd7 : in_frow[2:0];
    assign trow3  = (in_trow > 4'd7) ? 3'd7 : in_trow[2:0];

    always_comb
    begin
        d_rej   = 1'b0;
        d_empty = 1'b0;
        cs9     = col9;
        ce9     = col9;
        ps5     = pg5;
        pe5     = pg5;
        unique case (in_req)
            REQ_CLEAR:
            begin
                d_rej   = (col9 >= COLS9) || (pg5 >= PAGES5);
                d_empty = (wclip == 9'd0) || (hclip == 5'd0);
                ce9     = col9 + wclip - 9'd1;
                pe5     = pg5 + hclip - 5'd1;
            end
            REQ_INVERT:
            begin
                d_rej = (pg5 >= PAGES5) || (tpg5 >= PAGES5) || (pg5 > tpg5)
                        || (col9 > tcol9);
                cs9   = ccol9;
                ce9   = ctcol9;
                pe5   = tpg5;
            end
            REQ_HLINE:
            begin
                d_rej = (pg5 >= PAGES5) || (col9 > tcol9) || (in_frow >= 4'(ROWS_PER_PAGE));
                cs9   = ccol9;
                ce9   = ctcol9;
            end
            REQ_VLINE:
            begin
                d_rej = (col9 >= COLS9) || (pg5 > tpg5);
                ps5   = cpg5;
                pe5   = ctpg5;
            end
            REQ_WRITE, REQ_READ:
            begin
                d_rej = (col9 >= COLS9) || (pg5 >= PAGES5);
            end
            default:
            begin
                d_rej = 1'b1;
            end
        endcase
    end

    // request registers
    req_t                  op_reg;
    logic                  rej_reg, skip_reg;
    logic [COL_IDX_W-1:0]  cs_reg, ce_reg, c_reg;
    logic [PAGE_IDX_W-1:0] ps_reg, pe_reg, p_reg;
    logic [2:0]            frow_reg, trow_reg;
    logic [7:0]            data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_req;
            rej_reg  <= d_rej;
            skip_reg <= d_rej || d_empty;
            cs_reg   <= COL_IDX_W'(cs9);
            ce_reg   <= COL_IDX_W'(ce9);
            ps_reg   <= PAGE_IDX_W'(ps5);
            pe_reg   <= PAGE_IDX_W'(pe5);
            c_reg    <= COL_IDX_W'(cs9);
            p_reg    <= PAGE_IDX_W'(ps5);
            frow_reg <= frow3;
            trow_reg <= trow3;
            data_reg <= in_data;
        end
        else if (cmd.step)
        begin
            if (c_reg == ce_reg)
            begin
                c_reg <= cs_reg;
                p_reg <= p_reg + 1'b1;
            end
            else
            begin
                c_reg <= c_reg + 1'b1;
            end
        end
    end

    // power-up clearing sweep address
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // frame store
    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        mem_q;
    logic [ADDR_W-1:0] addr, waddr;
    logic [7:0]        new_byte, wbyte, vmask;
    logic              we;

    assign addr = ADDR_W'(int'(p_reg) * SCREEN_COLUMNS + int'(c_reg));

    always_comb
    begin
        priority if (ps_reg == pe_reg)
        begin
            vmask = row_mask(frow_reg, trow_reg);
        end
        else if (p_reg == ps_reg)
        begin
            vmask = row_mask(frow_reg, 3'd7);
        end
        else if (p_reg == pe_reg)
        begin
            vmask = row_mask(3'd0, trow_reg);
        end
        else
        begin
            vmask = FULL_BYTE;
        end
    end

    always_comb
    begin
        unique case (op_reg)
            REQ_INVERT: new_byte = ~mem_q;
            REQ_HLINE:  new_byte = mem_q | (8'd1 << frow_reg);
            REQ_VLINE:  new_byte = vmask;
            REQ_WRITE:  new_byte = data_reg;
            default:    new_byte = 8'h00;
        endcase
    end

    assign we    = cmd.mem_wr || cmd.clr_wr;
    assign waddr = cmd.clr_wr ? clr_addr_reg : addr;
    assign wbyte = cmd.clr_wr ? 8'h00 : new_byte;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wbyte;
        end
        if (cmd.mem_rd)
        begin
            mem_q <= mem[addr];
        end
    end

    // result register
    logic [7:0] rd_out_reg;
    logic       rej_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rd_out_reg  <= (op_reg == REQ_READ && !rej_reg) ? mem_q : 8'h00;
            rej_out_reg <= rej_reg;
        end
    end

    assign m_axis_tdata = rd_out_reg;
    assign m_axis_tuser = rej_out_reg;

    assign status.skip      = skip_reg;
    assign status.need_read = (op_reg == REQ_INVERT) || (op_reg == REQ_HLINE)
                              || (op_reg == REQ_READ);
    assign status.is_read   = (op_reg == REQ_READ);
    assign status.last      = (c_reg == ce_reg) && (p_reg == pe_reg);
    assign status.clr_last  = (clr_addr_reg == ADDR_W'(STORE_BYTES - 1));

endmodule

/* src/page_framebuffer_draw_engine.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Page-organised monochrome frame store with clear, invert, line and byte
// access requests.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request per transaction: request code in tuser, the
//   operands in tdata. m_axis returns exactly one result per request: the
//   byte read (zero for everything but an accepted read) and a rejected flag.
//   the block holds one request at a time; s_axis_tready is high only when
//   the sequencer is idle. a finished result sits in the output register, so
//   the next request is taken while that result waits for the receiver.
//   sequence: a decode step, then per frame byte a single store write for
//   clear, vertical line and write byte, a read then a write of the single
//   port store for invert and horizontal line; a read reads the store once.
//   the output register is loaded last. a rejected or empty request goes
//   from decode straight to loading the output register.
//   after reset the store is swept to zero, one byte a cycle, over all
//   columns * pages = 1024 bytes; s_axis_tready stays low during the sweep.
//   when the receiver stalls, the result holds and the block finishes at most
//   one further request, then waits with that result until the register frees.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // column, to_column, page, to_page, width, height, from_row, to_row, data
    input  logic [pfb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [pfb_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_data
    output logic [pfb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // rejected
    output logic [pfb_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import pfb_pkg::*;

    pfb_cmd_t    cmd;
    pfb_status_t status;

    pfb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    pfb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .cmd          (cmd),
        .status       (status),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

/* src/pfb_checker.sv */
// ----------------------------------------------------------------------------
// pfb_checker
// Port-level checks of the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
module pfb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [pfb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [pfb_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a rejected request never returns data
    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("rejected request returned data");

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

endmodule

bind page_framebuffer_draw_engine pfb_checker u_pfb_checker (.*);
